FILE: hw/rtl/rational_arith_reduce_core_macros.svh
// Assertion macros shared by the checker.
`ifndef RATIONAL_ARITH_REDUCE_CORE_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_CORE_MACROS_SVH
`define RAR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RAR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/rar_pkg.sv
`default_nettype none
package rar_pkg;
  localparam int unsigned OperandWidthDef = 16;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;
endpackage
`default_nettype wire

FILE: hw/rtl/rational_arith_reduce_core.sv
// Channel | Direction | Handshake
// in      | input     | valid_i / stall_o
// out     | output    | valid_o / stall_i
// The front handles a beat in order: capture, multiply, then sum or select.
// The back runs Euclid on a shared restoring divider, one run per remainder step,
// then divides both parts by the gcd in two more such runs.
// Euclid needs at most about 45 remainder steps for 16-bit operands.
// Neither the front nor the back takes a new beat until its last one is passed on.
// Reset clears all control state; a stalled result holds its beat.
`default_nettype none
module rational_arith_reduce_core import rar_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            stall_o,
  input  wire logic [1:0]                 opcode_i,
  input  wire logic [OPERAND_WIDTH-1:0]   first_numerator_i,
  input  wire logic [OPERAND_WIDTH-1:0]   first_denominator_i,
  input  wire logic [OPERAND_WIDTH-1:0]   second_numerator_i,
  input  wire logic [OPERAND_WIDTH-1:0]   second_denominator_i,
  output logic                            valid_o,
  input  wire logic                       stall_i,
  output logic [2*OPERAND_WIDTH-1:0]      raw_numerator_o,
  output logic [2*OPERAND_WIDTH-2:0]      raw_denominator_o,
  output logic [2*OPERAND_WIDTH-1:0]      reduced_numerator_o,
  output logic [2*OPERAND_WIDTH-2:0]      reduced_denominator_o,
  output logic                            zero_gcd_error_o
);
  localparam int unsigned MagW = 2 * OPERAND_WIDTH + 1;
  localparam int unsigned QW = 2 * MagW + 2;
  logic fv, fs, qv, qs;
  logic fnn, fdn;
  logic [MagW-1:0] fnm, fdm;
  logic [QW-1:0] qd;

  rar_front #(.OperandWidth(OPERAND_WIDTH)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .opcode_i,
    .a_i(first_numerator_i), .b_i(first_denominator_i),
    .c_i(second_numerator_i), .d_i(second_denominator_i),
    .valid_o(fv), .stall_i(fs),
    .num_neg_o(fnn), .num_mag_o(fnm), .den_neg_o(fdn), .den_mag_o(fdm)
  );

  rar_queue #(.Width(QW)) u_queue (
    .clk_i, .rst_ni, .valid_i(fv), .stall_o(fs), .data_i({fnn, fnm, fdn, fdm}),
    .valid_o(qv), .stall_i(qs), .data_o(qd)
  );

  rar_back #(.OperandWidth(OPERAND_WIDTH)) u_back (
    .clk_i, .rst_ni, .valid_i(qv), .stall_o(qs),
    .num_neg_i(qd[QW-1]), .num_mag_i(qd[QW-2 -: MagW]),
    .den_neg_i(qd[MagW]), .den_mag_i(qd[MagW-1:0]),
    .valid_o, .stall_i,
    .raw_numerator_o, .raw_denominator_o, .reduced_numerator_o,
    .reduced_denominator_o, .zero_gcd_error_o
  );
endmodule
`default_nettype wire

FILE: hw/rtl/rar_front.sv
`default_nettype none
module rar_front import rar_pkg::*; #(
  parameter int unsigned OperandWidth = OperandWidthDef,
  localparam int unsigned MagW = 2 * OperandWidth + 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         stall_o,
  input  wire logic [1:0]              opcode_i,
  input  wire logic [OperandWidth-1:0] a_i,
  input  wire logic [OperandWidth-1:0] b_i,
  input  wire logic [OperandWidth-1:0] c_i,
  input  wire logic [OperandWidth-1:0] d_i,
  output logic                         valid_o,
  input  wire logic                    stall_i,
  output logic                         num_neg_o,
  output logic [MagW-1:0]              num_mag_o,
  output logic                         den_neg_o,
  output logic [MagW-1:0]              den_mag_o
);
  localparam int unsigned PW = 2 * OperandWidth;
  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_SUM  = 3'b100
  } fst_e;

  fst_e state_q, state_d;
  logic [OperandWidth-1:0] a_q, b_q, c_q, d_q;
  op_e op_q;
  logic [PW-1:0] p1_q, p2_q, p3_q;
  logic n1_q, n2_q, n3_q;
  logic busy_q;

  function automatic logic [OperandWidth-1:0] mag(input logic [OperandWidth-1:0] v);
    mag = v[OperandWidth-1] ? (~v + 1'b1) : v;
  endfunction

  logic [OperandWidth-1:0] ma, mb, mc, md, x1, y1, x2, y2;
  logic s1, s2;
  always_comb begin
    ma = mag(a_q);
    mb = mag(b_q);
    mc = mag(c_q);
    md = mag(d_q);
    x1 = ma; y1 = md; s1 = a_q[OperandWidth-1] ^ d_q[OperandWidth-1];
    x2 = mc; y2 = mb; s2 = c_q[OperandWidth-1] ^ b_q[OperandWidth-1];
    if (op_q == OP_MUL) begin
      x1 = ma; y1 = mc; s1 = a_q[OperandWidth-1] ^ c_q[OperandWidth-1];
    end
  end

  logic [MagW-1:0] e1, e2, sum;
  logic sneg2;
  always_comb begin
    e1 = {1'b0, p1_q};
    e2 = {1'b0, p2_q};
    sneg2 = n2_q ^ (op_q == OP_SUB);
    if (n1_q == sneg2) begin
      sum = e1 + e2;
    end else if (e1 >= e2) begin
      sum = e1 - e2;
    end else begin
      sum = e2 - e1;
    end
  end

  assign stall_o = busy_q;
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (valid_i) state_d = F_MUL;
      F_MUL: state_d = F_SUM;
      F_SUM: if (!stall_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end
  assign valid_o = state_q == F_SUM;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      busy_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q <= (state_d != F_IDLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && valid_i && !busy_q) begin
      a_q <= a_i; b_q <= b_i; c_q <= c_i; d_q <= d_i;
      op_q <= op_e'(opcode_i);
    end
    if (state_q == F_MUL) begin
      p1_q <= PW'(x1) * PW'(y1);
      n1_q <= s1;
      p2_q <= PW'(x2) * PW'(y2);
      n2_q <= s2;
      p3_q <= PW'(mb) * PW'(md);
      n3_q <= b_q[OperandWidth-1] ^ d_q[OperandWidth-1];
    end
  end

  always_comb begin
    num_mag_o = e1;
    num_neg_o = n1_q;
    den_mag_o = {1'b0, p3_q};
    den_neg_o = n3_q;
    if (op_q == OP_ADD || op_q == OP_SUB) begin
      num_mag_o = sum;
      num_neg_o = (n1_q == sneg2 || e1 >= e2) ? n1_q : sneg2;
    end else if (op_q == OP_DIV) begin
      den_mag_o = e2;
      den_neg_o = n2_q;
    end
    if (num_mag_o == '0) num_neg_o = 1'b0;
    if (den_mag_o == '0) den_neg_o = 1'b0;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rar_queue.sv
`default_nettype none
module rar_queue #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  stall_o,
  input  wire logic [Width-1:0] data_i,
  output logic                  valid_o,
  input  wire logic             stall_i,
  output logic [Width-1:0]      data_o
);
  logic [1:0] full_q;
  logic [Width-1:0] mem_q [2];
  logic wp_q, rp_q;
  logic push, pop;
  assign stall_o = full_q[1];
  assign valid_o = full_q != 2'd0;
  assign push = valid_i && !full_q[1];
  assign pop = valid_o && !stall_i;
  assign data_o = mem_q[rp_q];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 2'd0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
    end else begin
      full_q <= full_q + {1'b0, push} - {1'b0, pop};
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rar_back.sv
`default_nettype none
module rar_back import rar_pkg::*; #(
  parameter int unsigned OperandWidth = OperandWidthDef,
  localparam int unsigned MagW = 2 * OperandWidth + 1,
  localparam int unsigned NumW = 2 * OperandWidth,
  localparam int unsigned DenW = 2 * OperandWidth - 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  stall_o,
  input  wire logic             num_neg_i,
  input  wire logic [MagW-1:0]  num_mag_i,
  input  wire logic             den_neg_i,
  input  wire logic [MagW-1:0]  den_mag_i,
  output logic                  valid_o,
  input  wire logic             stall_i,
  output logic [NumW-1:0]       raw_numerator_o,
  output logic [DenW-1:0]       raw_denominator_o,
  output logic [NumW-1:0]       reduced_numerator_o,
  output logic [DenW-1:0]       reduced_denominator_o,
  output logic                  zero_gcd_error_o
);
  localparam int unsigned CntW = $clog2(MagW + 1);
  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_GCD  = 6'b000010,
    B_DIVN = 6'b000100,
    B_DIVD = 6'b001000,
    B_FIN  = 6'b010000,
    B_OUT  = 6'b100000
  } bst_e;

  bst_e state_q;
  logic nn_q, dn_q, par_q;
  logic [MagW-1:0] nm_q, dm_q, x_q, y_q;
  // Shared restoring divider.
  logic [MagW-1:0] dvd_q, dvs_q, quo_q, rem_q, qn_q;
  logic [CntW-1:0] cnt_q;
  logic dbusy_q, dstart;
  logic [MagW:0] trial;
  logic [MagW-1:0] dvd_d, dvs_d;

  assign trial = {rem_q, dvd_q[MagW-1]} - {1'b0, dvs_q};
  assign stall_o = state_q != B_IDLE;
  assign valid_o = state_q == B_OUT;

  always_comb begin
    dstart = 1'b0;
    dvd_d = x_q;
    dvs_d = y_q;
    case (state_q)
      B_GCD: dstart = !dbusy_q && y_q != '0;
      B_DIVN: begin dstart = !dbusy_q; dvd_d = nm_q; dvs_d = x_q; end
      B_DIVD: begin dstart = !dbusy_q; dvd_d = dm_q; dvs_d = x_q; end
      default: dstart = 1'b0;
    endcase
  end

  logic [NumW-1:0] rn;
  logic [DenW-1:0] rd;
  logic g, sn, sd;
  always_comb begin
    g = par_q ? dn_q : nn_q;
    sn = nn_q ^ g;
    sd = dn_q ^ g;
    if (sd && quo_q != '0) sn = ~sn;
    rn = NumW'(sn ? (~qn_q + 1'b1) : qn_q);
    rd = DenW'(quo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      dbusy_q <= 1'b0;
    end else begin
      if (dstart) dbusy_q <= 1'b1;
      else if (dbusy_q && cnt_q == CntW'(1)) dbusy_q <= 1'b0;
      case (state_q)
        B_IDLE: if (valid_i) state_q <= B_GCD;
        B_GCD: if (!dbusy_q && y_q == '0) state_q <= (x_q == '0) ? B_FIN : B_DIVN;
        B_DIVN: if (dbusy_q && cnt_q == CntW'(1)) state_q <= B_DIVD;
        B_DIVD: if (dbusy_q && cnt_q == CntW'(1)) state_q <= B_FIN;
        B_FIN: state_q <= B_OUT;
        B_OUT: if (!stall_i) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && valid_i) begin
      nn_q <= num_neg_i; dn_q <= den_neg_i;
      nm_q <= num_mag_i; dm_q <= den_mag_i;
      x_q <= num_mag_i; y_q <= den_mag_i;
      par_q <= 1'b0;
    end
    if (dstart) begin
      dvd_q <= dvd_d; dvs_q <= dvs_d; rem_q <= '0; quo_q <= '0;
      cnt_q <= CntW'(MagW);
    end else if (dbusy_q) begin
      dvd_q <= {dvd_q[MagW-2:0], 1'b0};
      cnt_q <= cnt_q - 1'b1;
      if (!trial[MagW]) begin
        rem_q <= trial[MagW-1:0];
        quo_q <= {quo_q[MagW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[MagW-2:0], dvd_q[MagW-1]};
        quo_q <= {quo_q[MagW-2:0], 1'b0};
      end
      if (cnt_q == CntW'(1)) begin
        if (state_q == B_GCD) begin
          x_q <= y_q;
          y_q <= trial[MagW] ? {rem_q[MagW-2:0], dvd_q[MagW-1]} : trial[MagW-1:0];
          par_q <= ~par_q;
        end
      end
    end
    if (state_q == B_DIVD && dstart) qn_q <= quo_q;
    if (state_q == B_FIN) begin
      raw_numerator_o <= NumW'(nn_q ? (~nm_q + 1'b1) : nm_q);
      raw_denominator_o <= DenW'(dn_q ? (~dm_q + 1'b1) : dm_q);
      zero_gcd_error_o <= x_q == '0;
      reduced_numerator_o <= (x_q == '0) ? '0 : rn;
      reduced_denominator_o <= (x_q == '0) ? '0 : rd;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rar_checker.sv
`default_nettype none
`include "rational_arith_reduce_core_macros.svh"
module rar_checker import rar_pkg::*; #(
  parameter int unsigned OperandWidth = OperandWidthDef,
  localparam int unsigned NumW = 2 * OperandWidth,
  localparam int unsigned DenW = 2 * OperandWidth - 1
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            valid_o,
  input wire logic            stall_i,
  input wire logic [NumW-1:0] reduced_numerator_o,
  input wire logic [DenW-1:0] reduced_denominator_o,
  input wire logic            zero_gcd_error_o
);
  localparam logic [DenW-1:0] DenWrap = {1'b1, {(DenW-1){1'b0}}};
  `RAR_ASSERT_NXT(a_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(reduced_numerator_o))
  `RAR_ASSERT_IMP(a_err_zero, clk_i, rst_ni, valid_o && zero_gcd_error_o, reduced_numerator_o == '0 && reduced_denominator_o == '0)
  `RAR_ASSERT_IMP(a_den_pos, clk_i, rst_ni, valid_o && !zero_gcd_error_o, !reduced_denominator_o[DenW-1] || reduced_denominator_o == DenWrap)
endmodule
bind rational_arith_reduce_core rar_checker #(.OperandWidth(OPERAND_WIDTH)) u_rar_checker (
  .clk_i, .rst_ni, .valid_o, .stall_i, .reduced_numerator_o,
  .reduced_denominator_o, .zero_gcd_error_o
);
`default_nettype wire
